// ===== rtl/hsp_pkg.sv =====
package hsp_pkg;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 168;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned CALLS_W    = 32;
	localparam int unsigned ZONE_ID_W  = 4;
	localparam int unsigned ZONE_IDS   = 16;

	typedef enum logic [1:0] {
		OP_ENTER = 2'd0,
		OP_EXIT  = 2'd1,
		OP_SNAP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EN_WR,
		S_EX_RD,
		S_EX_TOT,
		S_EX_PRD,
		S_EX_PWR,
		S_RESP,
		S_SNAP
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  child;
		logic [TIME_W-1:0]  total;
		logic [CALLS_W-1:0] calls;
	} zone_entry_t;

endpackage

// ===== rtl/hsp_stack_mem.sv =====
module hsp_stack_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5,
	parameter int unsigned ZW    = 4
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [ZW-1:0]                  wzone,
	input  logic [hsp_pkg::TIME_W-1:0]     wstart,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr_a,
	input  logic [AW-1:0]                  raddr_b,
	output logic [ZW-1:0]                  rzone_a,
	output logic [hsp_pkg::TIME_W-1:0]     rstart_a,
	output logic [ZW-1:0]                  rzone_b
);

	logic [ZW-1:0]              zone_mem [DEPTH];
	logic [hsp_pkg::TIME_W-1:0] start_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			zone_mem[waddr]  <= wzone;
			start_mem[waddr] <= wstart;
		end
		if (re) begin
			rzone_a  <= zone_mem[raddr_a];
			rstart_a <= start_mem[raddr_a];
			rzone_b  <= zone_mem[raddr_b];
		end
	end

endmodule

// ===== rtl/hsp_zone_mem.sv =====
module hsp_zone_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 re,
	input  logic                 rclr,
	input  logic [AW-1:0]        raddr,
	output hsp_pkg::zone_entry_t rdata,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  hsp_pkg::zone_entry_t wdata
);

	hsp_pkg::zone_entry_t mem [DEPTH];
	hsp_pkg::zone_entry_t rraw_q;
	logic [DEPTH-1:0]     valid_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rraw_q <= mem[raddr];
		end
	end

	// entries read as zero until written, and again after a snapshot read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
			if (re && rclr) begin
				valid_q[raddr] <= 1'b0;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_q ? rraw_q : '0;

endmodule

// ===== rtl/hierarchical_scope_profiler.sv =====
// channel   dir  tdata (low bit up)                          tuser / tlast
// s_axis    in   zone_id[3:0] timestamp[67:4] pad[71:68]     tuser[1:0] opcode
// m_axis    out  status[1:0] report_zone[5:2] call_count[37:6]
//                total_time[101:38] child_time[165:102] pad  tlast last
//
// enter and exit (longer with a parent zone) are paced by read-modify-write through
// the single write port of the zone counter memory; snapshot reads zone by zone.
// reset clears the stack level and the per-zone valid bits at once; no clearing pass.
// a finished word waits in the output register while the next word is taken; the
// next result is held back in its state only if the register is still full.
module hierarchical_scope_profiler #(
	parameter int unsigned NUM_ZONES   = 16,
	parameter int unsigned STACK_DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [hsp_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // zone_id, timestamp
	input  logic [hsp_pkg::IN_USER_W-1:0]      s_axis_tuser,  // opcode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [hsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // status, report_zone,
	                                                          // call_count, total_time,
	                                                          // child_time
	output logic                               m_axis_tlast
);

	localparam int unsigned ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

	hsp_pkg::state_t  state_q, state_d;
	hsp_pkg::status_t status_q, status_d;
	logic [LW-1:0]    level_q, level_d;
	logic [hsp_pkg::TIME_W-1:0] ts_q, ts_d, elapsed_q, elapsed_d;
	logic [ZW-1:0]    zsel_q, zsel_d, par_q, par_d, idx_q, idx_d;
	logic             has_par_q, has_par_d;

	logic                           m_valid_q;
	logic [hsp_pkg::OUT_DATA_W-1:0] m_data_q;
	logic                           m_last_q;
	logic                           slot_free, load_out, out_last;
	hsp_pkg::status_t               out_status;
	hsp_pkg::zone_entry_t           out_entry;
	logic [ZW+3:0]                  out_zone_ext;

	logic [ZW-1:0] zmap [hsp_pkg::ZONE_IDS];
	logic [ZW-1:0] zone_in;
	hsp_pkg::op_t  op_in;
	logic          accept;

	logic          st_we, st_re;
	logic [ZW-1:0] st_rzone_a, st_rzone_b;
	logic [hsp_pkg::TIME_W-1:0] st_rstart_a;
	logic [LW-1:0] lvl_m1, lvl_m2;

	logic                 zm_re, zm_clr, zm_we;
	logic [ZW-1:0]        zm_raddr, zm_waddr;
	hsp_pkg::zone_entry_t zm_rdata, zm_wdata;

	for (genvar i = 0; i < hsp_pkg::ZONE_IDS; i++) begin : g_zmap
		assign zmap[i] = ZW'(i % NUM_ZONES);
	end

	assign zone_in   = zmap[s_axis_tdata[hsp_pkg::ZONE_ID_W-1:0]];
	assign op_in     = hsp_pkg::op_t'(s_axis_tuser[1:0]);
	assign s_axis_tready = (state_q == hsp_pkg::S_IDLE);
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !m_valid_q || m_axis_tready;
	assign lvl_m1    = level_q - LW'(1);
	assign lvl_m2    = level_q - LW'(2);

	hsp_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (SW),
		.ZW    (ZW)
	) u_stack (
		.clk      (clk),
		.we       (st_we),
		.waddr    (level_q[SW-1:0]),
		.wzone    (zone_in),
		.wstart   (s_axis_tdata[hsp_pkg::ZONE_ID_W +: hsp_pkg::TIME_W]),
		.re       (st_re),
		.raddr_a  (lvl_m1[SW-1:0]),
		.raddr_b  (has_par_d ? lvl_m2[SW-1:0] : '0),
		.rzone_a  (st_rzone_a),
		.rstart_a (st_rstart_a),
		.rzone_b  (st_rzone_b)
	);

	hsp_zone_mem #(
		.DEPTH (NUM_ZONES),
		.AW    (ZW)
	) u_zone (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (zm_re),
		.rclr   (zm_clr),
		.raddr  (zm_raddr),
		.rdata  (zm_rdata),
		.we     (zm_we),
		.waddr  (zm_waddr),
		.wdata  (zm_wdata)
	);

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		level_d    = level_q;
		ts_d       = ts_q;
		elapsed_d  = elapsed_q;
		zsel_d     = zsel_q;
		par_d      = par_q;
		idx_d      = idx_q;
		has_par_d  = has_par_q;
		st_we      = 1'b0;
		st_re      = 1'b0;
		zm_re      = 1'b0;
		zm_clr     = 1'b0;
		zm_raddr   = zone_in;
		zm_we      = 1'b0;
		zm_waddr   = zsel_q;
		zm_wdata   = zm_rdata;
		load_out   = 1'b0;
		out_status = status_q;
		out_entry  = '0;
		out_last   = 1'b1;
		unique case (state_q)
			hsp_pkg::S_IDLE: begin
				if (accept) begin
					status_d = hsp_pkg::STAT_OK;
					unique case (op_in)
						hsp_pkg::OP_ENTER: begin
							if (level_q == LW'(STACK_DEPTH)) begin
								status_d = hsp_pkg::STAT_OVERFLOW;
								state_d  = hsp_pkg::S_RESP;
							end else begin
								st_we   = 1'b1;
								zm_re   = 1'b1;
								zsel_d  = zone_in;
								level_d = level_q + LW'(1);
								state_d = hsp_pkg::S_EN_WR;
							end
						end
						hsp_pkg::OP_EXIT: begin
							if (level_q == '0) begin
								status_d = hsp_pkg::STAT_UNDERFLOW;
								state_d  = hsp_pkg::S_RESP;
							end else begin
								st_re     = 1'b1;
								has_par_d = (level_q > LW'(1));
								level_d   = lvl_m1;
								ts_d      = s_axis_tdata[hsp_pkg::ZONE_ID_W +: hsp_pkg::TIME_W];
								state_d   = hsp_pkg::S_EX_RD;
							end
						end
						hsp_pkg::OP_SNAP: begin
							zm_re    = 1'b1;
							zm_clr   = 1'b1;
							zm_raddr = '0;
							idx_d    = '0;
							state_d  = hsp_pkg::S_SNAP;
						end
						hsp_pkg::OP_NONE: begin
							state_d = hsp_pkg::S_RESP;
						end
					endcase
				end
			end
			hsp_pkg::S_EN_WR: begin
				zm_we          = 1'b1;
				zm_wdata.calls = zm_rdata.calls + hsp_pkg::CALLS_W'(1);
				state_d        = hsp_pkg::S_RESP;
			end
			hsp_pkg::S_EX_RD: begin
				elapsed_d = ts_q - st_rstart_a;
				zsel_d    = st_rzone_a;
				par_d     = st_rzone_b;
				zm_re     = 1'b1;
				zm_raddr  = st_rzone_a;
				state_d   = hsp_pkg::S_EX_TOT;
			end
			hsp_pkg::S_EX_TOT: begin
				zm_we          = 1'b1;
				zm_wdata.total = zm_rdata.total + elapsed_q;
				state_d        = has_par_q ? hsp_pkg::S_EX_PRD : hsp_pkg::S_RESP;
			end
			hsp_pkg::S_EX_PRD: begin
				zm_re    = 1'b1;
				zm_raddr = par_q;
				state_d  = hsp_pkg::S_EX_PWR;
			end
			hsp_pkg::S_EX_PWR: begin
				zm_we          = 1'b1;
				zm_waddr       = par_q;
				zm_wdata.child = zm_rdata.child + elapsed_q;
				state_d        = hsp_pkg::S_RESP;
			end
			hsp_pkg::S_RESP: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = hsp_pkg::S_IDLE;
				end
			end
			hsp_pkg::S_SNAP: begin
				out_status = hsp_pkg::STAT_OK;
				out_entry  = zm_rdata;
				out_last   = (idx_q == ZW'(NUM_ZONES - 1));
				if (slot_free) begin
					load_out = 1'b1;
					if (out_last) begin
						state_d = hsp_pkg::S_IDLE;
					end else begin
						idx_d    = idx_q + ZW'(1);
						zm_re    = 1'b1;
						zm_clr   = 1'b1;
						zm_raddr = idx_q + ZW'(1);
					end
				end
			end
		endcase
	end

	assign out_zone_ext = {4'b0, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hsp_pkg::S_IDLE;
			level_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		ts_q      <= ts_d;
		elapsed_q <= elapsed_d;
		zsel_q    <= zsel_d;
		par_q     <= par_d;
		idx_q     <= idx_d;
		has_par_q <= has_par_d;
		if (load_out) begin
			m_last_q <= out_last;
			m_data_q <= {2'b00, out_entry.child, out_entry.total, out_entry.calls,
				(state_q == hsp_pkg::S_SNAP) ? out_zone_ext[3:0] : 4'b0000, out_status};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule
